// ----- rtl/core/dksd_pkg.sv -----
// Shared types and constants for the debounced single-key decoder.
// No dependencies; imported by every module of the block.
package dksd_pkg;

   localparam int RAW_W       = 6;   // raw sample width per side
   localparam int KEY_CODE_W  = 4;
   localparam int SWITCH_W    = 4;
   localparam int DOOR_POS    = 4;   // door bit on the right side
   localparam int SHIFT_POS   = 5;   // shift bit on the right side
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   localparam int DEF_KEYS_PER_SIDE = 6;
   localparam int DEF_HISTORY_DEPTH = 3;

   typedef struct packed {
      logic [RAW_W-1:0]      right_clean;
      logic [RAW_W-1:0]      left_clean;
      logic [SWITCH_W-1:0]   switch_bits;
      logic [KEY_CODE_W-1:0] key_code;
   } rsp_type;

   typedef struct packed {
      logic lockout;
      logic held_nonzero;
   } merge_status_type;

endpackage

// ----- rtl/core/dksd_lane.sv -----
// One debounce lane: sample history and debounced level for one side.
// Depends on dksd_pkg.
module dksd_lane
   import dksd_pkg::*;
#(
   parameter int KEYS_PER_SIDE = DEF_KEYS_PER_SIDE,
   parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             sample_en,
   input  logic [RAW_W-1:0] sample,
   output logic [RAW_W-1:0] level_in
);

   localparam int UsedBits = (KEYS_PER_SIDE < RAW_W) ? KEYS_PER_SIDE : RAW_W;
   localparam logic [RAW_W-1:0] SideMask = RAW_W'((1 << UsedBits) - 1);

   logic [RAW_W-1:0] hist_ff [HISTORY_DEPTH];
   logic [RAW_W-1:0] level_ff;
   logic [RAW_W-1:0] masked;
   logic [RAW_W-1:0] any_high;
   logic [RAW_W-1:0] all_high;

   // oldest entry drops out, so the new window is entries 1..D-1 plus the sample
   always_comb begin
      masked   = sample & SideMask;
      any_high = masked;
      all_high = masked;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         any_high = any_high | hist_ff[i];
         all_high = all_high & hist_ff[i];
      end
      level_in = (level_ff & any_high) | all_high;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         level_ff <= '0;
      end else if (sample_en) begin
         for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            hist_ff[i] <= hist_ff[i+1];
         end
         hist_ff[HISTORY_DEPTH-1] <= masked;
         level_ff <= level_in;
      end
   end

endmodule

// ----- rtl/core/dksd_merge.sv -----
// Merge stage: builds the key set from both lanes and runs the single-key
// latch with lockout. Depends on dksd_pkg.
module dksd_merge
   import dksd_pkg::*;
#(
   parameter int KEYS_PER_SIDE = DEF_KEYS_PER_SIDE
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [RAW_W-1:0] left_level,
   input  logic [RAW_W-1:0] right_level,
   output rsp_type          result,
   output merge_status_type status
);

   localparam int KeyW  = KEYS_PER_SIDE + 1;
   localparam int CodeW = $clog2(2 * KEYS_PER_SIDE + 3);
   localparam logic [CodeW-1:0] PlainTop   = CodeW'(KEYS_PER_SIDE + 1);
   localparam logic [CodeW-1:0] ShiftSkip  = CodeW'(KEYS_PER_SIDE + 2);
   localparam logic [CodeW-1:0] KeyTop     = CodeW'(KEYS_PER_SIDE);

   logic [CodeW-1:0] held_code_ff, held_code_in;
   logic             lockout_ff, lockout_in;
   logic [KeyW-1:0]  keys;
   logic             shift;
   logic [CodeW-1:0] low_idx;
   logic [CodeW-1:0] test_bit;
   logic [KeyW-1:0]  keys_shifted;

   always_comb begin
      keys = '0;
      for (int i = 0; i < KEYS_PER_SIDE; i++) begin
         if (i < RAW_W) begin
            keys[i] = left_level[i];
         end
      end
      keys[KEYS_PER_SIDE] = right_level[DOOR_POS];
      shift = right_level[SHIFT_POS];

      // lowest set key; only used when exactly one is set
      low_idx = '0;
      for (int i = KeyW - 1; i >= 0; i--) begin
         if (keys[i]) begin
            low_idx = CodeW'(i);
         end
      end

      if (held_code_ff <= PlainTop) begin
         test_bit = held_code_ff - CodeW'(1);
      end else begin
         test_bit = held_code_ff - ShiftSkip;
      end
      keys_shifted = keys >> test_bit;

      held_code_in = held_code_ff;
      lockout_in   = lockout_ff;
      if (keys == '0) begin
         held_code_in = '0;
         lockout_in   = 1'b0;
      end else if (lockout_ff) begin
         // frozen until every key is released
      end else if (held_code_ff == '0) begin
         if ((keys & (keys - KeyW'(1))) == '0) begin
            held_code_in = low_idx + CodeW'(1) + (shift ? PlainTop : '0);
         end
      end else if (test_bit > KeyTop || !keys_shifted[0]) begin
         lockout_in = 1'b1;
      end

      result.key_code    = KEY_CODE_W'(held_code_in);
      result.switch_bits = right_level[SWITCH_W-1:0];
      result.left_clean  = left_level;
      result.right_clean = right_level;

      status.lockout      = lockout_ff;
      status.held_nonzero = (held_code_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_code_ff <= '0;
         lockout_ff   <= 1'b0;
      end else if (step_en) begin
         held_code_ff <= held_code_in;
         lockout_ff   <= lockout_in;
      end
   end

endmodule

// ----- rtl/core/dksd_outbuf.sv -----
// Two-entry result buffer: output register plus skid slot, so the input
// side keeps flowing while a result waits. Depends on dksd_pkg.
module dksd_outbuf
   import dksd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    can_push,
   input  logic    pop,
   output logic    head_valid,
   output rsp_type head_data
);

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff;
   rsp_type    skid_ff;

   assign can_push   = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = head_ff;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (count_ff == 2'd2) begin
            head_ff <= skid_ff;
            if (push) begin
               skid_ff <= push_data;
            end
         end else if (push) begin
            head_ff <= push_data;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_ff <= push_data;
         end else begin
            skid_ff <= push_data;
         end
      end
   end

endmodule

// ----- rtl/core/debounced_single_key_decoder_top.sv -----
// Top level of the debounced single-key decoder: two debounce lanes, the
// key merge stage and the result buffer. Depends on dksd_pkg and submodules.
//
//   Channel   Direction  Transfer when            Payload
//   req_      in         req_tvalid & req_tready left_raw, right_raw
//   rsp_      out        rsp_tvalid & rsp_tready key_code, switch_bits, left/right_clean
//
// One scan per cycle while req_tready is high: the lanes and the merge stage
// update their state in the cycle of the input transfer; the result is registered
// into the result buffer and reaches rsp_ behind any result still waiting. Reset
// (synchronous, active high) clears histories, levels, held code, lockout and the
// result buffer. A two-entry buffer keeps req_tready high while one result waits;
// it drops only when both are full, so in a back-to-back stream rsp_tready low stalls the input.
module debounced_single_key_decoder_top
   import dksd_pkg::*;
#(
   parameter int KEYS_PER_SIDE = DEF_KEYS_PER_SIDE,
   parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [5:0] left_raw, [11:6] right_raw
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [3:0] key_code, [7:4] switch_bits,
                                              // [13:8] left_clean, [19:14] right_clean
);

   logic             req_xfer;
   logic             rsp_xfer;
   logic [RAW_W-1:0] left_level;
   logic [RAW_W-1:0] right_level;
   rsp_type          result;
   rsp_type          head;
   merge_status_type status;

   assign req_xfer = req_tvalid & req_tready;
   assign rsp_xfer = rsp_tvalid & rsp_tready;

   dksd_lane #(
      .KEYS_PER_SIDE(KEYS_PER_SIDE),
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_left (
      .clock    (clock),
      .reset    (reset),
      .sample_en(req_xfer),
      .sample   (req_tdata[RAW_W-1:0]),
      .level_in (left_level)
   );

   dksd_lane #(
      .KEYS_PER_SIDE(KEYS_PER_SIDE),
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_right (
      .clock    (clock),
      .reset    (reset),
      .sample_en(req_xfer),
      .sample   (req_tdata[2*RAW_W-1:RAW_W]),
      .level_in (right_level)
   );

   dksd_merge #(
      .KEYS_PER_SIDE(KEYS_PER_SIDE)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .step_en    (req_xfer),
      .left_level (left_level),
      .right_level(right_level),
      .result     (result),
      .status     (status)
   );

   dksd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_data (result),
      .can_push  (req_tready),
      .pop       (rsp_xfer),
      .head_valid(rsp_tvalid),
      .head_data (head)
   );

   assign rsp_tdata = RSP_TDATA_W'(head);

   // lockout only ever follows a held code, and clears together with it
   assert property (@(posedge clock) disable iff (reset)
      status.lockout |-> status.held_nonzero)
      else $error("lockout set with no held code");

   // input side stalls only while results are waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty result buffer");

   // an accepted scan always leaves a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_tvalid)
      else $error("accepted scan produced no result");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
